// ===== rtl/msort_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and sizes for the merge sort engine cell chain.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned DataW    = 32;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [CntW-1:0]         cnt_t;

  // one slot of the chain: a value and whether it holds anything
  typedef struct packed {
    logic  vld;
    word_t val;
  } entry_t;

endpackage : msort_pkg
`default_nettype wire

// ===== rtl/msort_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msort_cell
// One sorting cell: keeps the smallest value seen, passes the larger one on.
// ----------------------------------------------------------------------------
module msort_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msort_pkg::entry_t ins_i,   // value arriving from the left
  input  logic             shift_i, // drain: take the right neighbor's slot
  input  msort_pkg::entry_t nxt_i,   // right neighbor's held slot
  output msort_pkg::entry_t held_o,
  output msort_pkg::entry_t carry_o
);
  import msort_pkg::*;

  entry_t held_q, held_d;
  entry_t carry_q, carry_d;

  always_comb begin
    held_d      = held_q;
    carry_d.vld = 1'b0;
    carry_d.val = ins_i.val;
    if (shift_i) begin
      held_d = nxt_i;
    end else if (ins_i.vld) begin
      if (!held_q.vld) begin
        held_d = ins_i;
      end else if (ins_i.val < held_q.val) begin
        held_d  = ins_i;
        carry_d = held_q;
      end else begin
        carry_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      carry_q <= '0;
    end else begin
      held_q  <= held_d;
      carry_q <= carry_d;
    end
  end

  assign held_o  = held_q;
  assign carry_o = carry_q;

endmodule : msort_cell
`default_nettype wire

// ===== rtl/merge_sort_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_engine_core
// Collects a set of signed 32-bit values and returns them in ascending order.
// ----------------------------------------------------------------------------
// A set is loaded one beat per cycle while in_ready_o is high; the beat with
// is_last_i closes it. Up to MaxItems (64) values are kept, later values of the
// same set are dropped but a late is_last still closes the set. Values go into a
// chain of 64 cells; each cell keeps the smallest value it has seen and hands
// the larger one to its right neighbor through its carry register, so the chain
// is always sorted once the ripple settles. After the closing beat the input
// stalls until the set is drained: the chain first settles until no carry is
// left, then drains one value per cycle from cell 0 while the whole chain shifts
// left, when the output slot is free or being emptied. The output is
// registered; the next set may start loading while the final beat of the
// previous one still waits to be taken.
// ----------------------------------------------------------------------------
module merge_sort_engine_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  msort_pkg::word_t      data_value_i,
  input  logic                  is_last_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output msort_pkg::word_t      sorted_value_o,
  output logic                  last_out_o
);
  import msort_pkg::*;

  typedef enum logic [1:0] {
    StLoad,
    StSettle,
    StDrain
  } state_e;

  state_e state_q;
  cnt_t   count_q;      // values held (load) / values left to emit (drain)
  logic   out_vld_q;
  word_t  out_val_q;
  logic   out_last_q;

  entry_t held  [MaxItems];
  entry_t carry [MaxItems];
  entry_t ins   [MaxItems];
  entry_t nxt   [MaxItems];

  logic in_beat;
  logic room;
  logic take;
  logic any_carry;

  assign in_ready_o = (state_q == StLoad);
  assign in_beat    = in_valid_i && in_ready_o;
  assign room       = (count_q < cnt_t'(MaxItems));
  // drain step: output slot free or being emptied this cycle
  assign take       = (state_q == StDrain) && (!out_vld_q || out_ready_i);

  // chain wiring: carries run right during insert, slots shift left on drain
  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      if (i == 0) begin
        ins[i].vld = in_beat && room;
        ins[i].val = data_value_i;
      end else begin
        ins[i] = carry[i-1];
      end
      if (i == MaxItems - 1) begin
        nxt[i] = '0;
      end else begin
        nxt[i] = held[i+1];
      end
    end
  end

  for (genvar g = 0; g < MaxItems; g++) begin : g_cell
    msort_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ins_i   (ins[g]),
      .shift_i (take),
      .nxt_i   (nxt[g]),
      .held_o  (held[g]),
      .carry_o (carry[g])
    );
  end

  always_comb begin
    any_carry = 1'b0;
    for (int i = 0; i < MaxItems; i++) begin
      any_carry = any_carry | carry[i].vld;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
      out_val_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      // slot empties unless a new beat refills it in the same cycle
      if (out_vld_q && out_ready_i && !take) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (in_beat) begin
            if (room) begin
              count_q <= count_q + cnt_t'(1);
            end
            if (is_last_i) begin
              state_q <= StSettle;
            end
          end
        end
        StSettle: begin
          if (!any_carry) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (take) begin
            out_vld_q  <= 1'b1;
            out_val_q  <= held[0].val;
            out_last_q <= (count_q == cnt_t'(1));
            count_q    <= count_q - cnt_t'(1);
            if (count_q == cnt_t'(1)) begin
              state_q <= StLoad;
            end
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sorted_value_o = out_val_q;
  assign last_out_o     = out_last_q;

endmodule : merge_sort_engine_core
`default_nettype wire
